[design/gpc_pkg.sv]
// Shared types and constants for the grid path counter.
package gpc_pkg;

  localparam int COLS_MAX   = 64;
  localparam int COL_W      = $clog2(COLS_MAX);
  localparam int ROW_W      = 16;
  localparam int COUNT_W    = 32;
  localparam int COLS_CFG_W = 7;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_COLS = 1'b0,
    REG_GRID_ROWS = 1'b1
  } cfg_reg_t;

  // Per-cell control carried from the walk stage to the update stage.
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             row0;
    logic             col0;
    logic             last;
    logic             fwd;
  } cell_tag_t;

endpackage

[design/gpc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
module gpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/gpc_walk.sv]
// Grid walk: configuration, cell position counters, row-store read issue.
module gpc_walk
  import gpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  accept,
  input  logic                  s1_go,
  output logic                  s1_valid,
  output cell_tag_t             s1_tag,
  output logic                  rd_en,
  output logic [COL_W-1:0]      rd_addr
);

  logic [COL_W-1:0]      cols_m1;
  logic [ROW_W-1:0]      rows_m1;
  logic [COL_W-1:0]      col;
  logic [ROW_W-1:0]      row;
  logic [COL_W-1:0]      cols_m1_next;
  logic [ROW_W-1:0]      rows_m1_next;
  logic [COLS_CFG_W-1:0] cols_cfg;
  logic                  end_row;
  logic                  last;

  assign cols_cfg = cfg_data[COLS_CFG_W-1:0];

  // Clamp column count into 1..COLS_MAX, row count into 1..max.
  always_comb begin
    if (cols_cfg == '0) begin
      cols_m1_next = '0;
    end else if (cols_cfg > COLS_CFG_W'(COLS_MAX)) begin
      cols_m1_next = COL_W'(COLS_MAX - 1);
    end else begin
      cols_m1_next = COL_W'(cols_cfg - COLS_CFG_W'(1));
    end
    if (cfg_data[ROW_W-1:0] == '0) begin
      rows_m1_next = '0;
    end else begin
      rows_m1_next = cfg_data[ROW_W-1:0] - ROW_W'(1);
    end
  end

  assign end_row = (col == cols_m1);
  assign last    = end_row && (row == rows_m1);
  assign rd_en   = accept && (row != '0);
  assign rd_addr = col;

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_m1  <= '0;
      rows_m1  <= '0;
      col      <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_GRID_COLS: cols_m1 <= cols_m1_next;
        REG_GRID_ROWS: rows_m1 <= rows_m1_next;
        default: ;
      endcase
      col <= '0;
      row <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        if (last) begin
          col <= '0;
          row <= '0;
        end else if (end_row) begin
          col <= '0;
          row <= row + ROW_W'(1);
        end else begin
          col <= col + COL_W'(1);
        end
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // A single-column grid reads the entry that the cell ahead writes this cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_tag.col  <= col;
      s1_tag.row0 <= (row == '0);
      s1_tag.col0 <= (col == '0);
      s1_tag.last <= last;
      s1_tag.fwd  <= s1_valid && (cols_m1 == '0);
    end
  end

endmodule

[design/gpc_cell.sv]
// Cell update: add above and left counts, saturate, write back, hold result.
module gpc_cell
  import gpc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s1_valid,
  input  cell_tag_t           s1_tag,
  input  logic                s1_blocked,
  input  logic [COUNT_W-1:0]  rd_data,
  output logic                s1_go,
  output logic                wr_en,
  output logic [COL_W-1:0]    wr_addr,
  output logic [COUNT_W-1:0]  wr_data,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [COUNT_W-1:0]  m_tdata,
  output logic                m_tuser
);

  logic [COUNT_W-1:0] last_value;
  logic [COUNT_W-1:0] up;
  logic [COUNT_W-1:0] left;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] value;

  always_comb begin
    if (s1_tag.row0) begin
      up = s1_tag.col0 ? COUNT_W'(1) : '0;
    end else if (s1_tag.fwd) begin
      up = last_value;
    end else begin
      up = rd_data;
    end
    left = s1_tag.col0 ? '0 : last_value;
    sum  = {1'b0, up} + {1'b0, left};
    // Blocked cells count zero.
    if (s1_blocked) begin
      value = '0;
    end else begin
      value = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
    end
  end

  // Hold the final cell while the previous result still waits.
  assign s1_go   = s1_valid && !(s1_tag.last && m_tvalid && !m_tready);
  assign wr_en   = s1_go;
  assign wr_addr = s1_tag.col;
  assign wr_data = value;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_value <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (s1_go) begin
        last_value <= value;
      end
      if (s1_go && s1_tag.last) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_tag.last) begin
      m_tdata <= value;
      m_tuser <= (value == COUNT_MAX);
    end
  end

endmodule

[design/grid_path_count_with_obstacles_core.sv]
// Top level of the grid path counter with obstacles.
//
//   channel   handshake            payload
//   s_*       s_tvalid / s_tready  s_tdata[0] = blocked
//   m_*       m_tvalid / m_tready  m_tdata = path_count, m_tuser = saturated
//   cfg_*     cfg_we               cfg_index (0 cols, 1 rows), cfg_data
//
// One cell per cycle while no waiting result stalls input; a cell passes a
// row-store read, then add and write-back. The single-port-write row store
// with registered read sets this; a single-column grid forwards the count
// just written. The last cell's update registers the result. Reset clears
// position, sizes (1 x 1) and the output valid; the row store is not cleared.
// A waiting result stalls input only when the next grid's last cell arrives.
module grid_path_count_with_obstacles_core
  import gpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [0] blocked, [7:1] zero
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [COUNT_W-1:0]   m_tdata,   // [31:0] path_count
  output logic                 m_tuser,   // [0] saturated
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic               accept;
  logic               s1_go;
  logic               s1_valid;
  cell_tag_t          s1_tag;
  logic               s1_blocked;
  logic               rd_en;
  logic [COL_W-1:0]   rd_addr;
  logic [COUNT_W-1:0] rd_data;
  logic               wr_en;
  logic [COL_W-1:0]   wr_addr;
  logic [COUNT_W-1:0] wr_data;

  assign s_tready = !s1_valid || s1_go;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_blocked <= s_tdata[0];
    end
  end

  gpc_walk u_walk (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .s1_go     (s1_go),
    .s1_valid  (s1_valid),
    .s1_tag    (s1_tag),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr)
  );

  gpc_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (COLS_MAX)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  gpc_cell u_cell (
    .clk        (clk),
    .rst        (rst),
    .s1_valid   (s1_valid),
    .s1_tag     (s1_tag),
    .s1_blocked (s1_blocked),
    .rd_data    (rd_data),
    .s1_go      (s1_go),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule
